@@ sv/usbrx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package usbrx_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int LENGTH_BITS  = 14;
  localparam int ERR_BIT      = 22;   // receive error flag in the header word

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PAD     = 2'd2
  } phase_t;

endpackage

`default_nettype wire

@@ sv/usb_bulk_rx_frame_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bulk receive deframer.
// Input channel: in_valid / in_stall with data_byte and transfer_end, one word
// per cycle unless in_stall; transfer_end marks a bulk transfer's last byte.
// Output channel: out_valid / out_stall with frame_byte, frame_end and
// frame_abort; one word per payload byte of a frame without receive error.
// Each frame is a 10-byte header (length and error flag in its first
// little-endian 32-bit word), the payload, then padding to a 4-byte boundary.
// Errored and zero-length frames give no words. A transfer that ends inside a
// payload marks its last delivered byte with frame_abort; downstream drops it.
// A payload byte appears on the output in the cycle after it is taken.
// Throughput: one byte per cycle while out_stall is low; the parser state is
// a few small counters updated in the same cycle as the byte is taken.
// The output register is the only buffer: in_stall is high exactly while a
// word is held and out_stall is high, so a receiver stall backs up the input.
// Reset (rst, synchronous) returns the parser to the header phase at offset
// zero and empties the output register.
module usb_bulk_rx_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       transfer_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      frame_byte,
  output logic            frame_end,
  output logic            frame_abort
);
  import usbrx_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  phase_t                 parse_phase, parse_phase_next;
  logic [3:0]             header_count, header_count_next;
  logic [23:0]            header_word, header_word_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  logic                   frame_good, frame_good_next;
  logic [1:0]             offset_mod4, offset_mod4_next;

  logic                   in_acc;
  logic                   emit, emit_end, emit_abort;
  logic [3:0]             cnt_inc;
  logic [23:0]            hdr_cur;
  logic                   final_byte;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // next-state logic
  always_comb begin
    parse_phase_next  = parse_phase;
    header_count_next = header_count;
    header_word_next  = header_word;
    payload_left_next = payload_left;
    frame_good_next   = frame_good;
    offset_mod4_next  = offset_mod4 + 2'd1;
    cnt_inc           = header_count + 4'd1;
    hdr_cur           = header_word;
    final_byte        = (payload_left <= LEN_ONE);

    case (parse_phase)
      PH_PAYLOAD: begin
        if (final_byte) begin
          header_count_next = '0;
          header_word_next  = '0;
          payload_left_next = '0;
          frame_good_next   = 1'b0;
          parse_phase_next  = (offset_mod4_next == 2'd0) ? PH_HEADER : PH_PAD;
        end else begin
          payload_left_next = payload_left - LEN_ONE;
        end
      end
      PH_PAD: begin
        if (offset_mod4_next == 2'd0) parse_phase_next = PH_HEADER;
      end
      default: begin
        case (header_count)
          4'd0:    hdr_cur[7:0]   = header_word[7:0]   | data_byte;
          4'd1:    hdr_cur[15:8]  = header_word[15:8]  | data_byte;
          4'd2:    hdr_cur[23:16] = header_word[23:16] | data_byte;
          default: hdr_cur        = header_word;
        endcase
        header_word_next  = hdr_cur;
        header_count_next = cnt_inc;
        if (({1'b0, cnt_inc} >= 5'(HEADER_BYTES)) || (cnt_inc == 4'd0)) begin
          if (hdr_cur[LENGTH_BITS-1:0] == '0) begin
            // zero-length frame: nothing to pass on, go straight to padding
            header_count_next = '0;
            header_word_next  = '0;
            payload_left_next = '0;
            frame_good_next   = 1'b0;
            parse_phase_next  = (offset_mod4_next == 2'd0) ? PH_HEADER : PH_PAD;
          end else begin
            header_count_next = '0;
            payload_left_next = hdr_cur[LENGTH_BITS-1:0];
            frame_good_next   = !hdr_cur[ERR_BIT];
            parse_phase_next  = PH_PAYLOAD;
          end
        end
      end
    endcase

    if (transfer_end) begin
      parse_phase_next  = PH_HEADER;
      header_count_next = '0;
      header_word_next  = '0;
      payload_left_next = '0;
      frame_good_next   = 1'b0;
      offset_mod4_next  = '0;
    end
  end

  // result logic
  always_comb begin
    emit       = 1'b0;
    emit_end   = 1'b0;
    emit_abort = 1'b0;
    case (parse_phase)
      PH_PAYLOAD: begin
        emit       = frame_good;
        emit_end   = final_byte;
        emit_abort = transfer_end && !final_byte;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_HEADER;
      header_count <= '0;
      header_word  <= '0;
      payload_left <= '0;
      frame_good   <= 1'b0;
      offset_mod4  <= '0;
    end else if (in_acc) begin
      parse_phase  <= parse_phase_next;
      header_count <= header_count_next;
      header_word  <= header_word_next;
      payload_left <= payload_left_next;
      frame_good   <= frame_good_next;
      offset_mod4  <= offset_mod4_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= in_acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      frame_byte  <= data_byte;
      frame_end   <= emit_end;
      frame_abort <= emit_abort;
    end
  end

endmodule

`default_nettype wire
